@@ hdl/lpfd_pkg.sv @@
// ----------------------------------------------------------------------------
// Frame deframer package
// Types and constants shared by the deframer modules.
// ----------------------------------------------------------------------------
package lpfd_pkg;

  localparam int unsigned HdrPosW = 4;

  localparam logic [HdrPosW-1:0] HdrBytes = 4'd10;

  localparam logic [7:0] MagicHi = 8'hCA;
  localparam logic [7:0] MagicLo = 8'hFE;

  localparam logic [7:0] FrameVersionReset = 8'd1;

  typedef enum logic [2:0] {
    SecHeader  = 3'd0,
    SecChannel = 3'd1,
    SecSession = 3'd2,
    SecPayload = 3'd3,
    SecTrail   = 3'd4
  } section_e;

  typedef enum logic [2:0] {
    StOk        = 3'd0,
    StMagic     = 3'd1,
    StVersion   = 3'd2,
    StShortHdr  = 3'd3,
    StShortBody = 3'd4
  } status_e;

  typedef struct packed {
    section_e    section;
    logic [7:0]  data_out;
    logic [7:0]  frame_flags;
    logic [7:0]  channel_len;
    logic [7:0]  session_len;
    logic [31:0] payload_len;
    logic        done_res;
    status_e     status;
  } out_word_t;

endpackage

@@ hdl/lpfd_in_if.sv @@
// ----------------------------------------------------------------------------
// Deframer input channel
// Valid/ready channel that carries one received byte and its last flag.
// ----------------------------------------------------------------------------
interface lpfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

@@ hdl/lpfd_out_if.sv @@
// ----------------------------------------------------------------------------
// Deframer output channel
// Valid/ready channel that carries one tagged byte and the frame verdict.
// ----------------------------------------------------------------------------
interface lpfd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  section;
  logic [7:0]  data_out;
  logic [7:0]  frame_flags;
  logic [7:0]  channel_len;
  logic [7:0]  session_len;
  logic [31:0] payload_len;
  logic        done_res;
  logic [2:0]  status;

  modport source (
    output valid, output section, output data_out, output frame_flags,
    output channel_len, output session_len, output payload_len,
    output done_res, output status, input ready
  );
  modport sink (
    input valid, input section, input data_out, input frame_flags,
    input channel_len, input session_len, input payload_len,
    input done_res, input status, output ready
  );
endinterface

@@ hdl/lpfd_parser.sv @@
// ----------------------------------------------------------------------------
// Frame deframer parser
// Holds the frame state and works out the tagged result of one byte.
// ----------------------------------------------------------------------------
module lpfd_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                advance_i,
  input  logic [7:0]          data_byte_i,
  input  logic                last_byte_i,
  input  logic [7:0]          frame_version_i,
  output lpfd_pkg::out_word_t result_o
);

  typedef struct packed {
    lpfd_pkg::section_e sec;
    logic [31:0]        rem;
  } entry_t;

  logic [lpfd_pkg::HdrPosW-1:0] hdr_pos_q, hdr_pos_d;
  lpfd_pkg::section_e           body_q, body_d;
  logic [31:0]                  rem_q, rem_d;
  logic [7:0]                   chan_len_q, chan_len_d;
  logic [7:0]                   sess_len_q, sess_len_d;
  logic [31:0]                  pay_len_q, pay_len_d;
  logic [7:0]                   flags_q, flags_d;
  lpfd_pkg::status_e            err_q, err_d;
  lpfd_pkg::section_e           sec;
  lpfd_pkg::status_e            status;
  entry_t                       entry;

  function automatic entry_t enter_section(logic [2:0] start, logic [7:0] ch,
                                           logic [7:0] se, logic [31:0] pl);
    entry_t e;
    if (start <= 3'(lpfd_pkg::SecChannel) && ch != 8'd0) begin
      e.sec = lpfd_pkg::SecChannel;
      e.rem = {24'd0, ch};
    end else if (start <= 3'(lpfd_pkg::SecSession) && se != 8'd0) begin
      e.sec = lpfd_pkg::SecSession;
      e.rem = {24'd0, se};
    end else if (start <= 3'(lpfd_pkg::SecPayload) && pl != 32'd0) begin
      e.sec = lpfd_pkg::SecPayload;
      e.rem = pl;
    end else begin
      e.sec = lpfd_pkg::SecTrail;
      e.rem = 32'd0;
    end
    return e;
  endfunction

  always_comb begin
    hdr_pos_d  = hdr_pos_q;
    body_d     = body_q;
    rem_d      = rem_q;
    chan_len_d = chan_len_q;
    sess_len_d = sess_len_q;
    pay_len_d  = pay_len_q;
    flags_d    = flags_q;
    err_d      = err_q;
    status     = lpfd_pkg::StOk;
    entry      = '0;

    if (hdr_pos_q < lpfd_pkg::HdrBytes) begin
      sec = lpfd_pkg::SecHeader;
      unique case (hdr_pos_q)
        4'd0: begin
          flags_d    = 8'd0;
          chan_len_d = 8'd0;
          sess_len_d = 8'd0;
          pay_len_d  = 32'd0;
          if (data_byte_i != lpfd_pkg::MagicHi && err_q == lpfd_pkg::StOk) begin
            err_d = lpfd_pkg::StMagic;
          end
        end
        4'd1: begin
          if (data_byte_i != lpfd_pkg::MagicLo && err_q == lpfd_pkg::StOk) begin
            err_d = lpfd_pkg::StMagic;
          end
        end
        4'd2: begin
          if (data_byte_i != frame_version_i && err_q == lpfd_pkg::StOk) begin
            err_d = lpfd_pkg::StVersion;
          end
        end
        4'd3: flags_d = data_byte_i;
        4'd4: chan_len_d = data_byte_i;
        4'd5: sess_len_d = data_byte_i;
        4'd6: pay_len_d[7:0] = data_byte_i;
        4'd7: pay_len_d[15:8] = data_byte_i;
        4'd8: pay_len_d[23:16] = data_byte_i;
        4'd9: pay_len_d[31:24] = data_byte_i;
        default: ;
      endcase
      hdr_pos_d = hdr_pos_q + 4'd1;
      if (hdr_pos_d == lpfd_pkg::HdrBytes) begin
        entry  = enter_section(3'(lpfd_pkg::SecChannel), chan_len_d, sess_len_d, pay_len_d);
        body_d = entry.sec;
        rem_d  = entry.rem;
      end
    end else if (body_q == lpfd_pkg::SecChannel || body_q == lpfd_pkg::SecSession ||
                 body_q == lpfd_pkg::SecPayload) begin
      sec   = body_q;
      rem_d = rem_q - 32'd1;
      if (rem_d == 32'd0) begin
        entry  = enter_section(3'(body_q) + 3'd1, chan_len_q, sess_len_q, pay_len_q);
        body_d = entry.sec;
        rem_d  = entry.rem;
      end
    end else begin
      sec    = lpfd_pkg::SecTrail;
      body_d = lpfd_pkg::SecTrail;
    end

    if (last_byte_i) begin
      if (hdr_pos_d < lpfd_pkg::HdrBytes) begin
        status = lpfd_pkg::StShortHdr;
      end else if (err_d != lpfd_pkg::StOk) begin
        status = err_d;
      end else if (body_d != lpfd_pkg::SecTrail) begin
        status = lpfd_pkg::StShortBody;
      end
      hdr_pos_d = '0;
      body_d    = lpfd_pkg::SecHeader;
      rem_d     = 32'd0;
      err_d     = lpfd_pkg::StOk;
    end
  end

  assign result_o.section     = sec;
  assign result_o.data_out    = data_byte_i;
  assign result_o.frame_flags = flags_d;
  assign result_o.channel_len = chan_len_d;
  assign result_o.session_len = sess_len_d;
  assign result_o.payload_len = pay_len_d;
  assign result_o.done_res    = last_byte_i;
  assign result_o.status      = status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_pos_q  <= '0;
      body_q     <= lpfd_pkg::SecHeader;
      rem_q      <= 32'd0;
      chan_len_q <= 8'd0;
      sess_len_q <= 8'd0;
      pay_len_q  <= 32'd0;
      flags_q    <= 8'd0;
      err_q      <= lpfd_pkg::StOk;
    end else if (advance_i) begin
      hdr_pos_q  <= hdr_pos_d;
      body_q     <= body_d;
      rem_q      <= rem_d;
      chan_len_q <= chan_len_d;
      sess_len_q <= sess_len_d;
      pay_len_q  <= pay_len_d;
      flags_q    <= flags_d;
      err_q      <= err_d;
    end
  end

  // The header count never runs past the header length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hdr_pos_q <= lpfd_pkg::HdrBytes)
    else $error("header position beyond header length");

  // The body section is the header phase exactly while the header is open.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hdr_pos_q < lpfd_pkg::HdrBytes) == (body_q == lpfd_pkg::SecHeader))
    else $error("body section out of step with header position");

  // A byte count is pending exactly while a length-carrying section is open.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rem_q != 32'd0) == (body_q == lpfd_pkg::SecChannel ||
                         body_q == lpfd_pkg::SecSession ||
                         body_q == lpfd_pkg::SecPayload))
    else $error("remaining count out of step with body section");

  // Only magic and version errors are ever held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q == lpfd_pkg::StOk || err_q == lpfd_pkg::StMagic ||
    err_q == lpfd_pkg::StVersion)
    else $error("unexpected held error code");

endmodule

@@ hdl/length_prefixed_frame_deframer.sv @@
// ----------------------------------------------------------------------------
// Length-prefixed frame deframer
// Checks a ten-byte header and tags each later byte of the buffer.
// ----------------------------------------------------------------------------
// The deframer gives one result word for each input word; the word passes
// through the input register and the combinational parser into the output
// register. Input ready follows the output register, so a new word is taken
// every cycle as long as the downstream side takes results. The verdict comes
// with the result of the word marked last; body words are passed on before it
// and must be dropped by the consumer when the verdict is an error. The user
// must write the frame_version register only while no word is in flight; the
// block itself does not enforce this.
module length_prefixed_frame_deframer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  lpfd_in_if.sink    in_i,
  lpfd_out_if.source out_o
);

  logic                frame_version_q;
  logic [7:0]          version_q;
  logic                s1_valid_q;
  logic [7:0]          s1_byte_q;
  logic                s1_last_q;
  logic                out_valid_q;
  lpfd_pkg::out_word_t out_q;
  lpfd_pkg::out_word_t result;
  logic                out_free;
  logic                advance;

  assign out_free   = !out_valid_q || out_o.ready;
  assign advance    = s1_valid_q && out_free;
  assign in_i.ready = !s1_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      version_q       <= lpfd_pkg::FrameVersionReset;
      frame_version_q <= 1'b0;
    end else begin
      frame_version_q <= cfg_we_i;
      if (cfg_we_i) begin
        version_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_byte_q <= in_i.data_byte;
      s1_last_q <= in_i.last_byte;
    end
    if (advance) begin
      out_q <= result;
    end
  end

  lpfd_parser u_parser (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .advance_i       (advance),
    .data_byte_i     (s1_byte_q),
    .last_byte_i     (s1_last_q),
    .frame_version_i (version_q),
    .result_o        (result)
  );

  assign out_o.valid       = out_valid_q;
  assign out_o.section     = out_q.section;
  assign out_o.data_out    = out_q.data_out;
  assign out_o.frame_flags = out_q.frame_flags;
  assign out_o.channel_len = out_q.channel_len;
  assign out_o.session_len = out_q.session_len;
  assign out_o.payload_len = out_q.payload_len;
  assign out_o.done_res    = out_q.done_res;
  assign out_o.status      = out_q.status;

  // A verdict other than ok only ever comes with the last word of a buffer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.done_res) |-> out_q.status == lpfd_pkg::StOk)
    else $error("error verdict on a word that is not last");

  // A word that is not moved on stays in the input register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !out_free) |=> s1_valid_q && $stable(s1_byte_q))
    else $error("input register lost a stalled word");

  // A configuration write lands in the version register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_version_q |-> version_q == $past(cfg_wdata_i))
    else $error("version register missed a write");

endmodule

@@ test/lpfd_frame_checker.sv @@
// ----------------------------------------------------------------------------
// Frame deframer checker
// Watches the input and output channels of the deframer, predicts the tagged
// word and verdict for every accepted input word, and compares each accepted
// result word field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module lpfd_frame_checker
  import lpfd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  lpfd_in_if         in_mon,
  lpfd_out_if        out_mon,
  output int         mismatches_o,
  output int         results_due_o
);

  logic [7:0]   version_q;
  logic [3:0]   hdr_pos;
  section_e     next_sec;
  logic [31:0]  sec_left;
  logic [7:0]   flags_q;
  logic [7:0]   chan_len_q;
  logic [7:0]   sess_len_q;
  logic [31:0]  pay_len_q;
  status_e      first_err;

  out_word_t    expected_words[$];
  out_word_t    predicted;
  out_word_t    oldest;
  int           fails = 0;

  assign mismatches_o = fails;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fails++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
    end
  endtask

  function automatic logic [31:0] section_len(input logic [2:0] sec);
    case (sec)
      SecChannel: return {24'd0, chan_len_q};
      SecSession: return {24'd0, sess_len_q};
      SecPayload: return pay_len_q;
      default:    return 32'd0;
    endcase
  endfunction

  // Empty sections are skipped; past the payload every byte is trailing.
  task automatic enter_section(input logic [2:0] start);
    logic [2:0] sec;
    sec = start;
    while (sec <= SecPayload && section_len(sec) == 32'd0) begin
      sec++;
    end
    next_sec = section_e'(sec);
    sec_left = (sec <= SecPayload) ? section_len(sec) : 32'd0;
  endtask

  task automatic note_error(input status_e code);
    if (first_err == StOk) begin
      first_err = code;
    end
  endtask

  task automatic clear_frame();
    hdr_pos   = '0;
    next_sec  = SecHeader;
    sec_left  = '0;
    first_err = StOk;
  endtask

  task automatic deframe_byte(input logic [7:0] data, input logic is_last,
                              output out_word_t word);
    section_e sec;
    status_e  verdict;
    verdict = StOk;
    if (hdr_pos < HdrBytes) begin
      sec = SecHeader;
      case (hdr_pos)
        4'd0: begin
          flags_q    = '0;
          chan_len_q = '0;
          sess_len_q = '0;
          pay_len_q  = '0;
          if (data != MagicHi) note_error(StMagic);
        end
        4'd1: if (data != MagicLo) note_error(StMagic);
        4'd2: if (data != version_q) note_error(StVersion);
        4'd3: flags_q = data;
        4'd4: chan_len_q = data;
        4'd5: sess_len_q = data;
        default: pay_len_q = pay_len_q | ({24'd0, data} << (8 * (hdr_pos - 6)));
      endcase
      hdr_pos++;
      if (hdr_pos == HdrBytes) enter_section(SecChannel);
    end else if (next_sec >= SecChannel && next_sec <= SecPayload) begin
      sec = next_sec;
      sec_left--;
      if (sec_left == 32'd0) enter_section(sec + 3'd1);
    end else begin
      sec      = SecTrail;
      next_sec = SecTrail;
    end

    if (is_last) begin
      if (hdr_pos < HdrBytes) verdict = StShortHdr;
      else if (first_err != StOk) verdict = first_err;
      else if (next_sec != SecTrail) verdict = StShortBody;
      else verdict = StOk;
    end

    word.section     = sec;
    word.data_out    = data;
    word.frame_flags = flags_q;
    word.channel_len = chan_len_q;
    word.session_len = sess_len_q;
    word.payload_len = pay_len_q;
    word.done_res    = is_last;
    word.status      = verdict;

    if (is_last) clear_frame();
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      version_q  = FrameVersionReset;
      flags_q    = '0;
      chan_len_q = '0;
      sess_len_q = '0;
      pay_len_q  = '0;
      clear_frame();
      expected_words.delete();
      results_due_o <= 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("unexpected result word, data 0x%0h",
                                    out_mon.data_out));
        end else begin
          oldest = expected_words.pop_front();
          check_field("section", 32'(out_mon.section), 32'(oldest.section));
          check_field("data_out", 32'(out_mon.data_out), 32'(oldest.data_out));
          check_field("frame_flags", 32'(out_mon.frame_flags), 32'(oldest.frame_flags));
          check_field("channel_len", 32'(out_mon.channel_len), 32'(oldest.channel_len));
          check_field("session_len", 32'(out_mon.session_len), 32'(oldest.session_len));
          check_field("payload_len", out_mon.payload_len, oldest.payload_len);
          check_field("done_res", 32'(out_mon.done_res), 32'(oldest.done_res));
          check_field("status", 32'(out_mon.status), 32'(oldest.status));
        end
      end
      if (cfg_we_i) begin
        version_q = cfg_wdata_i;
      end
      if (in_mon.valid && in_mon.ready) begin
        deframe_byte(in_mon.data_byte, in_mon.last_byte, predicted);
        expected_words.insert(expected_words.size(), predicted);
      end
      results_due_o <= expected_words.size();
    end
  end

endmodule

@@ test/length_prefixed_frame_deframer_tb.sv @@
// ----------------------------------------------------------------------------
// Frame deframer testbench
// Feeds the deframer directed buffers and then random buffers, mostly well
// formed frames with random content and some damaged or truncated ones,
// under three idling patterns and several version settings. A separate
// checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module length_prefixed_frame_deframer_tb;
  import lpfd_pkg::*;

  localparam int  ResetCycles   = 5;
  localparam int  DrainCycles   = 6;
  localparam int  PhaseWords    = 450;
  localparam int  HoldOffCycles = 80;
  localparam int  CycleLimit    = 400000;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  int          tx_idle_pct;
  int          rx_idle_pct;
  logic        pressure_go;
  logic        hold_rx;
  logic [7:0]  version_now;
  logic [7:0]  frame_bytes[$];
  int          words_sent;
  int          cycles = 0;
  int          mismatches;
  int          results_due;

  lpfd_in_if  in_ch ();
  lpfd_out_if out_ch ();

  length_prefixed_frame_deframer u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  lpfd_frame_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .mismatches_o  (mismatches),
    .results_due_o (results_due)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_ch.ready <= !hold_rx && ($urandom_range(99) >= rx_idle_pct);
  end

  // The receiver stops for a long stretch while the sender keeps offering.
  initial begin
    hold_rx = 1'b0;
    wait (pressure_go);
    @(posedge clk_i);
    hold_rx = 1'b1;
    repeat (HoldOffCycles) @(posedge clk_i);
    hold_rx = 1'b0;
  end

  task automatic send_word(input logic [7:0] data, input logic is_last);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= data;
    in_ch.last_byte <= is_last;
    do @(posedge clk_i); while (!in_ch.ready);
    words_sent++;
  endtask

  task automatic send_buffer();
    foreach (frame_bytes[i]) begin
      send_word(frame_bytes[i], i == frame_bytes.size() - 1);
    end
  endtask

  function automatic logic [7:0] pick_len();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 2) return 8'($urandom_range(0, 255));
    if (roll < 25) return 8'd0;
    return 8'($urandom_range(1, 6));
  endfunction

  task automatic build_random_buffer();
    int unsigned     roll;
    int unsigned     n;
    logic [7:0]      hdr[10];
    logic [7:0]      clen;
    logic [7:0]      slen;
    logic [31:0]     plen;
    longint unsigned full_len;
    longint unsigned cut;
    frame_bytes.delete();
    roll = $urandom_range(99);
    if (roll < 8) begin
      n = $urandom_range(1, 14);
      repeat (n) frame_bytes.insert(frame_bytes.size(), 8'($urandom));
      return;
    end
    clen = pick_len();
    slen = pick_len();
    plen = ($urandom_range(99) < 6) ? $urandom : {24'd0, pick_len()};
    hdr[0] = ($urandom_range(99) < 6) ? 8'($urandom) : MagicHi;
    hdr[1] = ($urandom_range(99) < 6) ? 8'($urandom) : MagicLo;
    hdr[2] = ($urandom_range(99) < 8) ? 8'($urandom) : version_now;
    hdr[3] = 8'($urandom);
    hdr[4] = clen;
    hdr[5] = slen;
    hdr[6] = plen[7:0];
    hdr[7] = plen[15:8];
    hdr[8] = plen[23:16];
    hdr[9] = plen[31:24];
    full_len = 64'd10 + clen + slen + plen;
    if ($urandom_range(99) >= 30) full_len += $urandom_range(1, 3);
    if (full_len > 600 || $urandom_range(99) < 12) begin
      cut = $urandom_range(1, (full_len > 60) ? 60 : int'(full_len));
    end else begin
      cut = full_len;
    end
    for (longint unsigned i = 0; i < cut; i++) begin
      frame_bytes.insert(frame_bytes.size(), (i < 10) ? hdr[i] : 8'($urandom));
    end
  endtask

  task automatic run_traffic(input int target);
    int start;
    start = words_sent;
    while (words_sent - start < target) begin
      build_random_buffer();
      send_buffer();
    end
    in_ch.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    @(posedge clk_i);
    while (results_due != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_version(input logic [7:0] value);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    version_now = value;
  endtask

  initial begin
    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    in_ch.last_byte = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    words_sent      = 0;
    pressure_go     = 1'b0;
    version_now     = FrameVersionReset;
    tx_idle_pct     = 22;
    rx_idle_pct     = 65;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_version(FrameVersionReset);
    frame_bytes = '{8'h00};
    send_buffer();
    frame_bytes = '{MagicHi, MagicLo, 8'h01, 8'hFF, 8'h01, 8'h01, 8'h01, 8'h00,
                    8'h00, 8'h00, 8'h5A, 8'hA5, 8'hFF, 8'h00};
    send_buffer();
    frame_bytes = '{MagicHi, MagicLo, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                    8'h00, 8'h00};
    send_buffer();
    in_ch.valid <= 1'b0;

    write_version(8'h00);
    run_traffic(PhaseWords);

    tx_idle_pct = 65;
    rx_idle_pct = 22;
    write_version(8'hFF);
    run_traffic(PhaseWords);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_version(8'($urandom));
    pressure_go = 1'b1;
    run_traffic(PhaseWords);

    wait_idle();
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/lpfd_pkg.sv
hdl/lpfd_in_if.sv
hdl/lpfd_out_if.sv
hdl/lpfd_parser.sv
hdl/length_prefixed_frame_deframer.sv
test/lpfd_frame_checker.sv
test/length_prefixed_frame_deframer_tb.sv
